### src/dmx_pkg.sv
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared codes, limits and types of the DMX512 slot receiver.
// ----------------------------------------------------------------------------
package dmx_pkg;

   localparam int DataWidth    = 8;
   localparam int SlotWidth    = 10;
   localparam int TimeoutWidth = 11;
   localparam int TickWidth    = 8;
   localparam int ModeWidth    = 2;
   localparam int CsrIdxWidth  = 1;

   localparam logic [TimeoutWidth-1:0] TIMEOUT_LIMIT = 11'd1000;
   localparam logic [SlotWidth-1:0]    SLOT_MAX      = 10'd1023;

   typedef enum logic [ModeWidth-1:0] {
      MODE_BYTE = 2'd0,
      MODE_TICK = 2'd1,
      MODE_READ = 2'd2
   } mode_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_FIRST_SLOT = 1'b0,
      CSR_FOOTPRINT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic frame_ready;
      logic timeout_error;
   } frame_flags_type;

endpackage

### src/dmx_slot_store.sv
// ----------------------------------------------------------------------------
// dmx_slot_store
// Slot capture memory: one write port, one registered read port, and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module dmx_slot_store #(
   parameter int BUFFER_SLOTS = 16,
   parameter int AddrWidth    = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [AddrWidth-1:0]           wr_addr,
   input  logic [dmx_pkg::DataWidth-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [AddrWidth-1:0]           rd_addr,
   output logic [dmx_pkg::DataWidth-1:0]  rd_data,
   output logic                           clear_busy
);
   import dmx_pkg::*;

   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(BUFFER_SLOTS - 1);

   logic [DataWidth-1:0] store_mem [BUFFER_SLOTS];
   logic [DataWidth-1:0] rd_data_ff;
   logic [AddrWidth-1:0] clear_addr_ff;
   logic                 clear_active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else if (clear_active_ff) begin
         clear_addr_ff <= clear_addr_ff + AddrWidth'(1);
         if (clear_addr_ff == LastAddr) begin
            clear_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!reset && clear_active_ff) begin
         store_mem[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_active_ff;

endmodule

### src/dmx_frame_ctrl.sv
// ----------------------------------------------------------------------------
// dmx_frame_ctrl
// Frame tracking, slot counting, timeout and read address decode for one
// request per cycle while advance is high.
// ----------------------------------------------------------------------------
module dmx_frame_ctrl #(
   parameter int BUFFER_SLOTS = 16,
   parameter int AddrWidth    = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [dmx_pkg::ModeWidth-1:0]     mode,
   input  logic [dmx_pkg::DataWidth-1:0]     rx_data,
   input  logic                              rx_ninth,
   input  logic                              framing_error,
   input  logic                              overrun,
   input  logic [dmx_pkg::TickWidth-1:0]     tick_amount,
   input  logic [dmx_pkg::SlotWidth-1:0]     channel,
   input  logic [dmx_pkg::SlotWidth-1:0]     first_slot,
   input  logic [dmx_pkg::SlotWidth-1:0]     footprint,
   output logic                              wr_en,
   output logic [AddrWidth-1:0]              wr_addr,
   output logic [dmx_pkg::DataWidth-1:0]     wr_data,
   output logic                              rd_en,
   output logic [AddrWidth-1:0]              rd_addr,
   output logic                              read_hit,
   output dmx_pkg::frame_flags_type          flags
);
   import dmx_pkg::*;

   localparam logic [SlotWidth-1:0] SlotsCount = SlotWidth'(BUFFER_SLOTS);
   localparam logic [SlotWidth-1:0] LastOffset = SlotWidth'(BUFFER_SLOTS - 1);

   logic                    break_seen_ff, break_seen_in;
   logic                    frame_open_ff, frame_open_in;
   logic [SlotWidth-1:0]    slot_count_ff, slot_count_in;
   logic [TimeoutWidth-1:0] timeout_count_ff, timeout_count_in;
   logic                    error_flag_ff, error_flag_in;
   logic                    ready_flag_ff, ready_flag_in;

   logic [SlotWidth-1:0]    slot_step;
   logic [SlotWidth-1:0]    slot_offset;
   logic                    in_window;
   logic [SlotWidth-1:0]    ch_clamped;
   logic [SlotWidth-1:0]    ch_index;

   // Read address: clamp to footprint, then treat channel zero as one.
   always_comb begin
      ch_clamped = (channel > footprint) ? footprint : channel;
      if (ch_clamped == '0) begin
         ch_clamped = SlotWidth'(1);
      end
      ch_index = ch_clamped - SlotWidth'(1);
      read_hit = (ch_index < SlotsCount);
      rd_addr  = ch_index[AddrWidth-1:0];
   end

   assign slot_step   = (slot_count_ff < SLOT_MAX) ? slot_count_ff + SlotWidth'(1)
                                                   : slot_count_ff;
   assign slot_offset = slot_step - first_slot;
   assign in_window   = (slot_step >= first_slot) && (slot_offset < SlotsCount);
   assign wr_addr     = slot_offset[AddrWidth-1:0];
   assign wr_data     = rx_data;

   always_comb begin
      break_seen_in    = break_seen_ff;
      frame_open_in    = frame_open_ff;
      slot_count_in    = slot_count_ff;
      timeout_count_in = timeout_count_ff;
      error_flag_in    = error_flag_ff;
      ready_flag_in    = ready_flag_ff;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      unique case (mode)
         MODE_BYTE: begin
            if (overrun || framing_error) begin
               // drop the whole frame; a zero byte with framing error, no overrun and ninth bit low is a break
               break_seen_in    = framing_error && !overrun &&
                                  (rx_data == '0) && !rx_ninth;
               frame_open_in    = 1'b0;
               slot_count_in    = '0;
               timeout_count_in = '0;
               error_flag_in    = 1'b0;
               ready_flag_in    = 1'b0;
            end else if (break_seen_ff) begin
               if (rx_data == '0) begin
                  frame_open_in = 1'b1;
               end
               break_seen_in = 1'b0;
            end else if (frame_open_ff) begin
               slot_count_in = slot_step;
               if (in_window) begin
                  wr_en = advance;
                  if (slot_offset == LastOffset) begin
                     ready_flag_in = 1'b1;
                     break_seen_in = 1'b0;
                     frame_open_in = 1'b0;
                  end
               end
            end
         end
         MODE_TICK: begin
            if (timeout_count_ff < TIMEOUT_LIMIT) begin
               timeout_count_in = timeout_count_ff + TimeoutWidth'(tick_amount);
            end else begin
               error_flag_in = 1'b1;
            end
         end
         MODE_READ: begin
            ready_flag_in = 1'b0;
            rd_en         = advance && read_hit;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         break_seen_ff    <= 1'b0;
         frame_open_ff    <= 1'b0;
         slot_count_ff    <= '0;
         timeout_count_ff <= '0;
         error_flag_ff    <= 1'b0;
         ready_flag_ff    <= 1'b0;
      end else if (advance) begin
         break_seen_ff    <= break_seen_in;
         frame_open_ff    <= frame_open_in;
         slot_count_ff    <= slot_count_in;
         timeout_count_ff <= timeout_count_in;
         error_flag_ff    <= error_flag_in;
         ready_flag_ff    <= ready_flag_in;
      end
   end

   // State only moves together with the response register, so it always
   // matches the response on display.
   assign flags.frame_ready   = ready_flag_ff;
   assign flags.timeout_error = error_flag_ff;

endmodule

### src/dmx512_slot_receiver.sv
// ----------------------------------------------------------------------------
// dmx512_slot_receiver
// DMX512 receiver: takes UART byte events, time ticks and channel reads,
// captures a window of slots and answers each request with one response.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-----------------------
//   request | req_mode .. req_channel        | req_valid / req_ready
//   result  | rsp_channel_value, rsp_flags.. | rsp_valid / rsp_ready
//   config  | csr_index, csr_write_data      | csr_write_enable
//
// A request sits in the input register and is decoded on its way into the
// response register, which drives the response; one request per cycle is
// sustained while rsp_ready stays high. The store is swept to zero after
// reset, one entry per cycle, so req_ready stays low until the sweep ends.
// The response register holds while rsp_valid is high and rsp_ready is low;
// the input register takes a new request as long as it can move its
// current one forward.
// ----------------------------------------------------------------------------
module dmx512_slot_receiver #(
   parameter int BUFFER_SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dmx_pkg::ModeWidth-1:0]        req_mode,
   input  logic [dmx_pkg::DataWidth-1:0]        req_rx_data,
   input  logic                                 req_rx_ninth,
   input  logic                                 req_framing_error,
   input  logic                                 req_overrun,
   input  logic [dmx_pkg::TickWidth-1:0]        req_tick_amount,
   input  logic [dmx_pkg::SlotWidth-1:0]        req_channel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dmx_pkg::DataWidth-1:0]        rsp_channel_value,
   output logic                                 rsp_frame_ready,
   output logic                                 rsp_timeout_error,
   input  logic                                 csr_write_enable,
   input  logic [dmx_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [dmx_pkg::SlotWidth-1:0]        csr_write_data
);
   import dmx_pkg::*;

   localparam int AddrWidth = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;

   logic [SlotWidth-1:0]    first_slot_ff;
   logic [SlotWidth-1:0]    footprint_ff;

   logic                    in_valid_ff;
   logic [ModeWidth-1:0]    in_mode_ff;
   logic [DataWidth-1:0]    in_rx_data_ff;
   logic                    in_rx_ninth_ff;
   logic                    in_framing_error_ff;
   logic                    in_overrun_ff;
   logic [TickWidth-1:0]    in_tick_amount_ff;
   logic [SlotWidth-1:0]    in_channel_ff;

   logic                    out_valid_ff;
   logic                    value_sel_ff;

   logic                    out_free;
   logic                    advance;
   logic                    clear_busy;
   logic                    wr_en;
   logic [AddrWidth-1:0]    wr_addr;
   logic [DataWidth-1:0]    wr_data;
   logic                    rd_en;
   logic [AddrWidth-1:0]    rd_addr;
   logic [DataWidth-1:0]    rd_data;
   logic                    read_hit;
   frame_flags_type         flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_slot_ff <= SlotWidth'(1);
         footprint_ff  <= SlotWidth'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIRST_SLOT: first_slot_ff <= csr_write_data;
            CSR_FOOTPRINT:  footprint_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !clear_busy && (!in_valid_ff || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff          <= req_mode;
         in_rx_data_ff       <= req_rx_data;
         in_rx_ninth_ff      <= req_rx_ninth;
         in_framing_error_ff <= req_framing_error;
         in_overrun_ff       <= req_overrun;
         in_tick_amount_ff   <= req_tick_amount;
         in_channel_ff       <= req_channel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_sel_ff <= (in_mode_ff == MODE_READ) && read_hit;
      end
   end

   dmx_frame_ctrl #(
      .BUFFER_SLOTS (BUFFER_SLOTS),
      .AddrWidth    (AddrWidth)
   ) u_frame_ctrl (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .mode          (in_mode_ff),
      .rx_data       (in_rx_data_ff),
      .rx_ninth      (in_rx_ninth_ff),
      .framing_error (in_framing_error_ff),
      .overrun       (in_overrun_ff),
      .tick_amount   (in_tick_amount_ff),
      .channel       (in_channel_ff),
      .first_slot    (first_slot_ff),
      .footprint     (footprint_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .read_hit      (read_hit),
      .flags         (flags)
   );

   dmx_slot_store #(
      .BUFFER_SLOTS (BUFFER_SLOTS),
      .AddrWidth    (AddrWidth)
   ) u_slot_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_value = value_sel_ff ? rd_data : '0;
   assign rsp_frame_ready   = flags.frame_ready;
   assign rsp_timeout_error = flags.timeout_error;

endmodule

### src/dmx_checker.sv
// ----------------------------------------------------------------------------
// dmx_checker
// Port-level checks of the DMX512 slot receiver, bound to the top level.
// ----------------------------------------------------------------------------
module dmx_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [dmx_pkg::ModeWidth-1:0]        req_mode,
   input  logic [dmx_pkg::DataWidth-1:0]        req_rx_data,
   input  logic                                 req_rx_ninth,
   input  logic                                 req_framing_error,
   input  logic                                 req_overrun,
   input  logic [dmx_pkg::TickWidth-1:0]        req_tick_amount,
   input  logic [dmx_pkg::SlotWidth-1:0]        req_channel,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [dmx_pkg::DataWidth-1:0]        rsp_channel_value,
   input  logic                                 rsp_frame_ready,
   input  logic                                 rsp_timeout_error,
   input  logic                                 csr_write_enable,
   input  logic [dmx_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [dmx_pkg::SlotWidth-1:0]        csr_write_data
);
   import dmx_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_value) &&
      $stable(rsp_frame_ready) && $stable(rsp_timeout_error))
      else $error("response changed while stalled");

   // a nonzero value only comes from a read, which clears frame_ready
   a_read_clears_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_channel_value != '0) |-> !rsp_frame_ready)
      else $error("read response shows frame_ready");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // the store sweep keeps requests out after reset
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during store sweep");

endmodule

bind dmx512_slot_receiver dmx_checker u_checker (.*);
